[rtl/core/bgi_pkg.sv]
package bgi_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned FRAC_W     = 25;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned WIDX_W     = 6;
  localparam int unsigned PTS_W      = 7;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << 24;

  localparam logic [CFG_IDX_W-1:0] CFG_X_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RECIP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_RECIP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PTS_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PTS_Q   = 3'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_DIFF,
    FE_MUL_LO,
    FE_MUL_HI,
    FE_CELL,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_READ,
    BE_COL,
    BE_COL_WAIT,
    BE_ROW,
    BE_ROW_WAIT
  } be_state_e;

endpackage

[rtl/core/bgi_queue.sv]
module bgi_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/core/bgi_front.sv]
module bgi_front #(
  parameter int unsigned MAX_POINTS_X = 64,
  parameter int unsigned MAX_POINTS_Q = 64,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned XW           = 6,
  parameter int unsigned QW           = 6,
  parameter int unsigned EW           = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bgi_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  log_x_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  log_q_i,
  input  logic [bgi_pkg::WIDX_W-1:0]          write_x_index_i,
  input  logic [bgi_pkg::WIDX_W-1:0]          write_q_index_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  transverse_value_i,
  input  logic                                transverse_present_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  longitudinal_value_i,
  input  logic                                longitudinal_present_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output logic [EW-1:0]                       q_data_o,
  output logic [XW-1:0]                       nx_last_o,
  output logic [QW-1:0]                       nq_last_o
);
  import bgi_pkg::*;

  localparam int unsigned PXW = $clog2(MAX_POINTS_X + 1);
  localparam int unsigned PQW = $clog2(MAX_POINTS_Q + 1);
  localparam logic signed [63:0] VMAX = 64'sd1 <<< (VALUE_WIDTH - 1);

  fe_state_e state_q, state_d;

  logic signed [31:0] x_first_q, x_last_q, q_first_q, q_last_q;
  logic [31:0]        x_recip_q, q_recip_q;
  logic [PTS_W-1:0]   pts_x_q, pts_q_q;

  logic signed [31:0] lx_q, lq_q;
  logic               ax_q;
  logic [31:0]        d_q;
  logic [47:0]        acc_q, pos_q;
  logic               clamped_q;
  logic [XW-1:0]      i_q;
  logic [QW-1:0]      j_q;
  logic [FRAC_W-1:0]  t_q;
  logic [31:0]        clamp_cnt_q;

  logic [PXW-1:0] nx;
  logic [PQW-1:0] nq;
  logic [XW-1:0]  lim_x;
  logic [QW-1:0]  lim_q;

  logic               accept, in_range;
  logic signed [31:0] coord, first, last, v1, v2;
  logic [31:0]        rsel;
  logic signed [32:0] diff;
  logic               out_of_grid;
  logic [15:0]        mop;
  logic [47:0]        prod;
  logic [23:0]        cell_idx, lim24;
  logic               over;
  logic [FRAC_W-1:0]  frac;
  logic [23:0]        idx;
  logic [VALUE_WIDTH-1:0] tv_sat, lv_sat;
  logic signed [63:0] tv_ext, lv_ext;
  logic [EW-1:0]      wr_entry, qr_entry;

  always_comb begin
    if (pts_x_q < PTS_W'(2)) begin
      nx = PXW'(2);
    end else if (32'(pts_x_q) > MAX_POINTS_X) begin
      nx = PXW'(MAX_POINTS_X);
    end else begin
      nx = PXW'(pts_x_q);
    end
    if (pts_q_q < PTS_W'(2)) begin
      nq = PQW'(2);
    end else if (32'(pts_q_q) > MAX_POINTS_Q) begin
      nq = PQW'(MAX_POINTS_Q);
    end else begin
      nq = PQW'(pts_q_q);
    end
  end

  assign nx_last_o = XW'(nx - PXW'(1));
  assign nq_last_o = QW'(nq - PQW'(1));
  assign lim_x     = XW'(nx - PXW'(2));
  assign lim_q     = QW'(nq - PQW'(2));

  assign busy     = (state_q != FE_IDLE) || q_full_i;
  assign accept   = start && !busy;
  assign in_range = (32'(write_x_index_i) < MAX_POINTS_X) &&
                    (32'(write_q_index_i) < MAX_POINTS_Q);

  // axis clamp and distance
  assign coord = ax_q ? lq_q : lx_q;
  assign first = ax_q ? q_first_q : x_first_q;
  assign last  = ax_q ? q_last_q : x_last_q;
  assign rsel  = ax_q ? q_recip_q : x_recip_q;
  assign out_of_grid = (coord < first) || (coord > last);
  assign v1   = (coord < first) ? first : coord;
  assign v2   = (v1 > last) ? last : v1;
  assign diff = 33'(v2) - 33'(first);

  assign mop  = (state_q == FE_MUL_LO) ? d_q[15:0] : d_q[31:16];
  assign prod = 48'(mop) * 48'(rsel);

  assign cell_idx = pos_q[47:24];
  assign lim24    = ax_q ? 24'(lim_q) : 24'(lim_x);
  assign over     = cell_idx > lim24;
  assign idx      = over ? lim24 : cell_idx;
  assign frac     = over ? FRAC_ONE : {1'b0, pos_q[23:0]};

  // stored values are limited to the value width
  assign tv_ext = 64'(transverse_value_i);
  assign lv_ext = 64'(longitudinal_value_i);
  always_comb begin
    if (tv_ext > VMAX - 64'sd1) begin
      tv_sat = VALUE_WIDTH'(VMAX - 64'sd1);
    end else if (tv_ext < -VMAX) begin
      tv_sat = VALUE_WIDTH'(-VMAX);
    end else begin
      tv_sat = VALUE_WIDTH'(tv_ext);
    end
    if (lv_ext > VMAX - 64'sd1) begin
      lv_sat = VALUE_WIDTH'(VMAX - 64'sd1);
    end else if (lv_ext < -VMAX) begin
      lv_sat = VALUE_WIDTH'(-VMAX);
    end else begin
      lv_sat = VALUE_WIDTH'(lv_ext);
    end
  end

  assign wr_entry = {OP_WRITE, XW'(write_x_index_i), QW'(write_q_index_i),
                     {(2*FRAC_W+1){1'b0}}, tv_sat, transverse_present_i,
                     lv_sat, longitudinal_present_i};
  assign qr_entry = {OP_QUERY, i_q, j_q, t_q, frac, clamped_q || out_of_grid,
                     {(2*VALUE_WIDTH+2){1'b0}}};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: begin
        if (accept && op_i == OP_QUERY) state_d = FE_DIFF;
      end
      FE_DIFF:   state_d = FE_MUL_LO;
      FE_MUL_LO: state_d = FE_MUL_HI;
      FE_MUL_HI: state_d = FE_CELL;
      FE_CELL:   state_d = ax_q ? FE_PUSH : FE_DIFF;
      FE_PUSH: begin
        if (!q_full_i) state_d = FE_IDLE;
      end
      default:   state_d = FE_IDLE;
    endcase
  end

  always_comb begin
    q_push_o = 1'b0;
    q_data_o = wr_entry;
    unique case (state_q)
      FE_IDLE: q_push_o = accept && op_i == OP_WRITE && in_range;
      FE_PUSH: begin
        q_push_o = !q_full_i;
        q_data_o = {qr_entry[EW-1:2*VALUE_WIDTH+3], clamped_q,
                    {(2*VALUE_WIDTH+2){1'b0}}};
      end
      default: q_push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FE_IDLE;
      x_first_q   <= 32'sd0;
      x_last_q    <= 32'sd16777216;
      q_first_q   <= 32'sd0;
      q_last_q    <= 32'sd16777216;
      x_recip_q   <= 32'd4128768;
      q_recip_q   <= 32'd4128768;
      pts_x_q     <= PTS_W'(64);
      pts_q_q     <= PTS_W'(64);
      clamp_cnt_q <= 32'd0;
      ax_q        <= 1'b0;
      clamped_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_X_FIRST: x_first_q <= cfg_wdata_i;
          CFG_X_LAST:  x_last_q  <= cfg_wdata_i;
          CFG_Q_FIRST: q_first_q <= cfg_wdata_i;
          CFG_Q_LAST:  q_last_q  <= cfg_wdata_i;
          CFG_X_RECIP: x_recip_q <= cfg_wdata_i;
          CFG_Q_RECIP: q_recip_q <= cfg_wdata_i;
          CFG_PTS_X:   pts_x_q   <= cfg_wdata_i[PTS_W-1:0];
          CFG_PTS_Q:   pts_q_q   <= cfg_wdata_i[PTS_W-1:0];
          default:     ;
        endcase
      end
      if (state_q == FE_IDLE && accept) begin
        ax_q      <= 1'b0;
        clamped_q <= 1'b0;
      end
      if (state_q == FE_DIFF && out_of_grid) clamped_q <= 1'b1;
      if (state_q == FE_CELL) ax_q <= 1'b1;
      if (state_q == FE_PUSH && !q_full_i && clamped_q) clamp_cnt_q <= clamp_cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FE_IDLE && accept) begin
      lx_q <= log_x_i;
      lq_q <= log_q_i;
    end
    if (state_q == FE_DIFF) d_q <= diff[32] ? 32'd0 : diff[31:0];
    if (state_q == FE_MUL_LO) acc_q <= prod;
    if (state_q == FE_MUL_HI) pos_q <= prod + 48'(acc_q[47:16]);
    if (state_q == FE_CELL) begin
      if (ax_q) begin
        j_q <= QW'(idx);
      end else begin
        i_q <= XW'(idx);
        t_q <= frac;
      end
    end
  end

endmodule

[rtl/core/bgi_cubic.sv]
module bgi_cubic #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_WIDTH-1:0] p_i [4],
  input  logic [bgi_pkg::FRAC_W-1:0]    t_i,
  output logic signed [VALUE_WIDTH-1:0] res_o,
  output logic                          done_o
);
  import bgi_pkg::*;

  localparam int unsigned AW = VALUE_WIDTH + 8;
  localparam int unsigned OW = (AW - 24 > 25) ? AW - 24 : 25;
  localparam int unsigned PW = OW + 26;
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-VALUE_WIDTH+1){1'b0}},
                                             {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  logic signed [AW-1:0] pe [4];
  logic signed [AW-1:0] a_w, b_w, c_w, two_w;
  logic signed [AW-1:0] a_q, b_q, two_q, h_q, addend, h_d, half;
  logic [FRAC_W-1:0]    t_q;
  logic [24:0]          lo_q;
  logic [2:0]           cnt_q;
  logic                 run_q, done_q;
  logic signed [VALUE_WIDTH-1:0] res_q;
  logic signed [OW-1:0] hi_w, lo_w, mop;
  logic signed [PW-1:0] prod;

  always_comb begin
    for (int n = 0; n < 4; n++) pe[n] = AW'(p_i[n]);
  end

  assign a_w   = pe[2] - pe[0];
  assign b_w   = (pe[0] <<< 1) - ((pe[1] <<< 2) + pe[1]) + (pe[2] <<< 2) - pe[3];
  assign c_w   = pe[3] - pe[0] + ((pe[1] <<< 1) + pe[1]) - ((pe[2] <<< 1) + pe[2]);
  assign two_w = pe[1] <<< 1;

  // horner step split as high part times t plus low part times t
  assign hi_w = OW'(h_q >>> 24);
  assign lo_w = OW'($signed({1'b0, h_q[23:0]}));
  assign mop  = cnt_q[0] ? hi_w : lo_w;
  assign prod = PW'(mop) * PW'($signed({1'b0, t_q}));

  always_comb begin
    case (cnt_q[2:1])
      2'd0:    addend = b_q;
      2'd1:    addend = a_q;
      default: addend = two_q;
    endcase
  end

  assign h_d  = AW'(prod) + AW'($signed({1'b0, lo_q})) + addend;
  assign half = h_q >>> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 3'd0;
      end else if (run_q) begin
        if (cnt_q == 3'd6) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_w;
      b_q   <= b_w;
      two_q <= two_w;
      h_q   <= c_w;
      t_q   <= t_i;
    end else if (run_q) begin
      if (cnt_q == 3'd6) begin
        if (half > SAT_HI) begin
          res_q <= VALUE_WIDTH'(SAT_HI);
        end else if (half < SAT_LO) begin
          res_q <= VALUE_WIDTH'(SAT_LO);
        end else begin
          res_q <= VALUE_WIDTH'(half);
        end
      end else if (!cnt_q[0]) begin
        lo_q <= prod[48:24];
      end else begin
        h_q <= h_d;
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

[rtl/core/bgi_back.sv]
module bgi_back #(
  parameter int unsigned MAX_POINTS_X = 64,
  parameter int unsigned MAX_POINTS_Q = 64,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned XW           = 6,
  parameter int unsigned QW           = 6,
  parameter int unsigned EW           = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  logic [EW-1:0]                     q_data_i,
  output logic                              q_pop_o,
  input  logic [XW-1:0]                     nx_last_i,
  input  logic [QW-1:0]                     nq_last_i,
  output logic                              done_o,
  output logic signed [bgi_pkg::RES_W-1:0]  transverse_result_o,
  output logic                              transverse_valid_o,
  output logic signed [bgi_pkg::RES_W-1:0]  longitudinal_result_o,
  output logic                              longitudinal_valid_o,
  output logic                              was_clamped_o
);
  import bgi_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic signed [63:0] RMAX = 64'sd2147483647;
  localparam logic signed [63:0] RMIN = -64'sd2147483648;

  be_state_e state_q, state_d;

  logic [VW:0] mem_t_q [MAX_POINTS_X][MAX_POINTS_Q];
  logic [VW:0] mem_l_q [MAX_POINTS_X][MAX_POINTS_Q];
  logic [VW:0] rd_t_q, rd_l_q;

  logic               e_is_q, e_clamped, e_tp, e_lp;
  logic [XW-1:0]      e_a;
  logic [QW-1:0]      e_b;
  logic [FRAC_W-1:0]  e_t, e_u;
  logic [VW-1:0]      e_tv, e_lv;

  logic [XW-1:0]      i_q;
  logic [QW-1:0]      j_q;
  logic [FRAC_W-1:0]  t_q, u_q;
  logic               clamped_q;
  logic [4:0]         cnt_q;
  logic [1:0]         col_q;
  logic signed [VW-1:0] sten_t_q [16];
  logic signed [VW-1:0] sten_l_q [16];
  logic signed [VW-1:0] colv_t_q [4];
  logic signed [VW-1:0] colv_l_q [4];
  logic               pres_t_q, pres_l_q;

  logic               done_q, tvalid_q, lvalid_q, wclamp_q;
  logic signed [RES_W-1:0] tres_q, lres_q;

  logic [XW:0]        ax_w, a_w;
  logic [QW:0]        bx_w, b_w;
  logic [XW-1:0]      ra;
  logic [QW-1:0]      rb;
  logic               cub_start, col_phase;
  logic signed [VW-1:0] p_t [4];
  logic signed [VW-1:0] p_l [4];
  logic [FRAC_W-1:0]  cub_t;
  logic signed [VW-1:0] res_t, res_l;
  logic               cub_done, cub_done_l;
  logic               pop;
  logic signed [63:0] rt_ext, rl_ext;
  logic signed [RES_W-1:0] rt_sat, rl_sat;

  assign {e_is_q, e_a, e_b, e_t, e_u, e_clamped, e_tv, e_tp, e_lv, e_lp} = q_data_i;

  // stencil address, clamped at the grid border
  assign ax_w = {1'b0, i_q} + (XW+1)'(cnt_q[3:2]);
  assign bx_w = {1'b0, j_q} + (QW+1)'(cnt_q[1:0]);
  always_comb begin
    a_w = (ax_w == '0) ? '0 : ax_w - (XW+1)'(1);
    b_w = (bx_w == '0) ? '0 : bx_w - (QW+1)'(1);
    ra  = (a_w > {1'b0, nx_last_i}) ? nx_last_i : XW'(a_w);
    rb  = (b_w > {1'b0, nq_last_i}) ? nq_last_i : QW'(b_w);
  end

  always_ff @(posedge clk_i) begin
    if (pop && !e_is_q) begin
      mem_t_q[e_a][e_b] <= {e_tp, e_tv};
      mem_l_q[e_a][e_b] <= {e_lp, e_lv};
    end
    rd_t_q <= mem_t_q[ra][rb];
    rd_l_q <= mem_l_q[ra][rb];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE: begin
        if (!q_empty_i && e_is_q) state_d = BE_READ;
      end
      BE_READ: begin
        if (cnt_q == 5'd16) state_d = BE_COL;
      end
      BE_COL:  state_d = BE_COL_WAIT;
      BE_COL_WAIT: begin
        if (cub_done) state_d = (col_q == 2'd3) ? BE_ROW : BE_COL;
      end
      BE_ROW:  state_d = BE_ROW_WAIT;
      BE_ROW_WAIT: begin
        if (cub_done) state_d = BE_IDLE;
      end
      default: state_d = BE_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    cub_start = 1'b0;
    col_phase = 1'b1;
    unique case (state_q)
      BE_IDLE:     pop = !q_empty_i;
      BE_COL:      cub_start = 1'b1;
      BE_ROW: begin
        cub_start = 1'b1;
        col_phase = 1'b0;
      end
      BE_ROW_WAIT: col_phase = 1'b0;
      default:     ;
    endcase
  end

  assign q_pop_o = pop;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      p_t[n] = col_phase ? sten_t_q[{col_q, 2'(n)}] : colv_t_q[n];
      p_l[n] = col_phase ? sten_l_q[{col_q, 2'(n)}] : colv_l_q[n];
    end
  end
  assign cub_t = col_phase ? u_q : t_q;

  bgi_cubic #(
    .VALUE_WIDTH(VW)
  ) u_cub_t (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cub_start),
    .p_i    (p_t),
    .t_i    (cub_t),
    .res_o  (res_t),
    .done_o (cub_done)
  );

  bgi_cubic #(
    .VALUE_WIDTH(VW)
  ) u_cub_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cub_start),
    .p_i    (p_l),
    .t_i    (cub_t),
    .res_o  (res_l),
    .done_o (cub_done_l)
  );

  assign rt_ext = 64'(res_t);
  assign rl_ext = 64'(res_l);
  assign rt_sat = (rt_ext > RMAX) ? RES_W'(RMAX) : (rt_ext < RMIN) ? RES_W'(RMIN) :
                  RES_W'(rt_ext);
  assign rl_sat = (rl_ext > RMAX) ? RES_W'(RMAX) : (rl_ext < RMIN) ? RES_W'(RMIN) :
                  RES_W'(rl_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= 5'd0;
      col_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == BE_ROW_WAIT) && cub_done;
      if (state_q == BE_IDLE) begin
        cnt_q <= 5'd0;
        col_q <= 2'd0;
      end
      if (state_q == BE_READ) cnt_q <= cnt_q + 5'd1;
      if (state_q == BE_COL_WAIT && cub_done && cub_done_l) col_q <= col_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && e_is_q) begin
      i_q       <= e_a;
      j_q       <= e_b;
      t_q       <= e_t;
      u_q       <= e_u;
      clamped_q <= e_clamped;
      pres_t_q  <= 1'b1;
      pres_l_q  <= 1'b1;
    end
    if (state_q == BE_READ && cnt_q != 5'd0) begin
      sten_t_q[4'(cnt_q - 5'd1)] <= rd_t_q[VW-1:0];
      sten_l_q[4'(cnt_q - 5'd1)] <= rd_l_q[VW-1:0];
      pres_t_q <= pres_t_q && rd_t_q[VW];
      pres_l_q <= pres_l_q && rd_l_q[VW];
    end
    if (state_q == BE_COL_WAIT && cub_done) begin
      colv_t_q[col_q] <= res_t;
      colv_l_q[col_q] <= res_l;
    end
    if (state_q == BE_ROW_WAIT && cub_done) begin
      tres_q   <= pres_t_q ? rt_sat : '0;
      lres_q   <= pres_l_q ? rl_sat : '0;
      tvalid_q <= pres_t_q;
      lvalid_q <= pres_l_q;
      wclamp_q <= clamped_q;
    end
  end

  assign done_o                = done_q;
  assign transverse_result_o   = tres_q;
  assign transverse_valid_o    = tvalid_q;
  assign longitudinal_result_o = lres_q;
  assign longitudinal_valid_o  = lvalid_q;
  assign was_clamped_o         = wclamp_q;

endmodule

[rtl/core/bicubic_grid_interpolator_top.sv]
// bicubic grid interpolator over two log-domain tables
// requests: start with busy low accepts one request. op_i = 0 writes one entry
//   of both tables (indices beyond the table are dropped), op_i = 1 queries.
// config: cfg_we_i writes register cfg_idx_i with cfg_wdata_i in the same edge;
//   write only while no request is in flight.
// results: a query gives one result, shown for one cycle with done_o high.
//   a write gives none. the receiver cannot stall, so results never wait.
// stages: a query's locate stage runs two 16x32 products per axis on one
//   multiplier, then the queue push; the back stage pops it, reads the 4x4
//   stencil through one read port per table, then runs 5 cubic steps.
//   a two-entry request queue sits between the stages, so the front can take
//   a new query while the back stage still works on the last one, and back to
//   back queries are paced by the stencil reads and the cubic chain; a write
//   is pushed from the idle front stage and stored when the back stage pops it.
// reset: rst_ni clears control state and loads register defaults; table
//   contents stay undefined until written and need no clearing pass.
module bicubic_grid_interpolator_top #(
  parameter int unsigned MAX_POINTS_X = 64,
  parameter int unsigned MAX_POINTS_Q = 64,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bgi_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  log_x_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  log_q_i,
  input  logic [bgi_pkg::WIDX_W-1:0]          write_x_index_i,
  input  logic [bgi_pkg::WIDX_W-1:0]          write_q_index_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  transverse_value_i,
  input  logic                                transverse_present_i,
  input  logic signed [bgi_pkg::COORD_W-1:0]  longitudinal_value_i,
  input  logic                                longitudinal_present_i,
  output logic                                done_o,
  output logic signed [bgi_pkg::RES_W-1:0]    transverse_result_o,
  output logic                                transverse_valid_o,
  output logic signed [bgi_pkg::RES_W-1:0]    longitudinal_result_o,
  output logic                                longitudinal_valid_o,
  output logic                                was_clamped_o
);
  import bgi_pkg::*;

  localparam int unsigned XW = $clog2(MAX_POINTS_X);
  localparam int unsigned QW = $clog2(MAX_POINTS_Q);
  localparam int unsigned EW = 1 + XW + QW + 2*FRAC_W + 1 + 2*(VALUE_WIDTH + 1);

  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;
  logic [XW-1:0] nx_last;
  logic [QW-1:0] nq_last;

  bgi_front #(
    .MAX_POINTS_X(MAX_POINTS_X),
    .MAX_POINTS_Q(MAX_POINTS_Q),
    .VALUE_WIDTH (VALUE_WIDTH),
    .XW          (XW),
    .QW          (QW),
    .EW          (EW)
  ) u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .start                 (start),
    .busy                  (busy),
    .op_i                  (op_i),
    .log_x_i               (log_x_i),
    .log_q_i               (log_q_i),
    .write_x_index_i       (write_x_index_i),
    .write_q_index_i       (write_q_index_i),
    .transverse_value_i    (transverse_value_i),
    .transverse_present_i  (transverse_present_i),
    .longitudinal_value_i  (longitudinal_value_i),
    .longitudinal_present_i(longitudinal_present_i),
    .q_full_i              (q_full),
    .q_push_o              (q_push),
    .q_data_o              (q_wdata),
    .nx_last_o             (nx_last),
    .nq_last_o             (nq_last)
  );

  bgi_queue #(
    .W(EW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  bgi_back #(
    .MAX_POINTS_X(MAX_POINTS_X),
    .MAX_POINTS_Q(MAX_POINTS_Q),
    .VALUE_WIDTH (VALUE_WIDTH),
    .XW          (XW),
    .QW          (QW),
    .EW          (EW)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_empty_i            (q_empty),
    .q_data_i             (q_rdata),
    .q_pop_o              (q_pop),
    .nx_last_i            (nx_last),
    .nq_last_i            (nq_last),
    .done_o               (done_o),
    .transverse_result_o  (transverse_result_o),
    .transverse_valid_o   (transverse_valid_o),
    .longitudinal_result_o(longitudinal_result_o),
    .longitudinal_valid_o (longitudinal_valid_o),
    .was_clamped_o        (was_clamped_o)
  );

endmodule

[rtl/core/bgi_checker.sv]
module bgi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        op_i,
  input logic        done_o,
  input logic [31:0] transverse_result_o,
  input logic        transverse_valid_o,
  input logic [31:0] longitudinal_result_o,
  input logic        longitudinal_valid_o
);

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i |=> busy)
    else $error("query accepted without front going busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_trans_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !transverse_valid_o |-> transverse_result_o == 32'd0)
    else $error("absent transverse stencil gave nonzero result");

  a_long_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !longitudinal_valid_o |-> longitudinal_result_o == 32'd0)
    else $error("absent longitudinal stencil gave nonzero result");

endmodule

bind bicubic_grid_interpolator_top bgi_checker u_bgi_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start                (start),
  .busy                 (busy),
  .op_i                 (op_i),
  .done_o               (done_o),
  .transverse_result_o  (transverse_result_o),
  .transverse_valid_o   (transverse_valid_o),
  .longitudinal_result_o(longitudinal_result_o),
  .longitudinal_valid_o (longitudinal_valid_o)
);

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bgi_pkg::*;

  localparam int NPTS = 64;
  localparam int FILL = 20;
  localparam int STALL_LIMIT = 3000;
  localparam longint ONE_Q24 = 64'sd16777216;

  typedef struct {
    logic        op;
    logic [31:0] log_x;
    logic [31:0] log_q;
    logic [5:0]  wx;
    logic [5:0]  wq;
    logic [31:0] tval;
    logic        tpres;
    logic [31:0] lval;
    logic        lpres;
  } request_t;

  typedef struct {
    logic [31:0] tres;
    logic        tvalid;
    logic [31:0] lres;
    logic        lvalid;
    logic        clamped;
  } result_t;

  class interp_scoreboard;
    longint tv[NPTS*NPTS];
    longint lv[NPTS*NPTS];
    bit     tp[NPTS*NPTS];
    bit     lp[NPTS*NPTS];
    longint x_first, x_last, q_first, q_last;
    longint unsigned x_recip, q_recip;
    int     pts_x, pts_q;
    logic [31:0] clamp_count;
    result_t pending[$];
    int errors;
    int results_seen;

    function new();
      x_first = 0;
      x_last = ONE_Q24;
      q_first = 0;
      q_last = ONE_Q24;
      x_recip = 4128768;
      q_recip = 4128768;
      pts_x = 64;
      pts_q = 64;
      clamp_count = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_X_FIRST: x_first = longint'(signed'(val));
        CFG_X_LAST:  x_last = longint'(signed'(val));
        CFG_Q_FIRST: q_first = longint'(signed'(val));
        CFG_Q_LAST:  q_last = longint'(signed'(val));
        CFG_X_RECIP: x_recip = longint'(val);
        CFG_Q_RECIP: q_recip = longint'(val);
        CFG_PTS_X:   pts_x = int'(val[6:0]);
        CFG_PTS_Q:   pts_q = int'(val[6:0]);
        default: ;
      endcase
    endfunction

    function longint sat(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function longint mul_q24(longint v, longint t);
      return (v * t) >>> 24;
    endfunction

    function longint cubic(longint t, longint p0, longint p1, longint p2, longint p3);
      longint a, b, c, h;
      a = p2 - p0;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = -p0 + 3 * p1 - 3 * p2 + p3;
      h = mul_q24(c, t) + b;
      h = mul_q24(h, t) + a;
      h = mul_q24(h, t) + 2 * p1;
      return sat(h >>> 1, 32);
    endfunction

    function int limit_points(int n);
      return n < 2 ? 2 : (n > NPTS ? NPTS : n);
    endfunction

    function void find_cell(longint coord, longint first, longint last,
                            longint unsigned recip, int n, output int idx,
                            output longint frac, inout bit clamped);
      longint v, d;
      bit [63:0] prod, pos, cell_idx, fr;
      v = coord;
      if (coord < first || coord > last) clamped = 1;
      if (v < first) v = first;
      if (v > last) v = last;
      d = v - first;
      if (d < 0) d = 0;
      prod = 64'(d) * 64'(recip);
      pos = prod >> 16;
      cell_idx = pos >> 24;
      if (cell_idx > 64'(n - 2)) cell_idx = 64'(n - 2);
      fr = pos - (cell_idx << 24);
      if (fr > 64'(ONE_Q24)) fr = 64'(ONE_Q24);
      idx = int'(cell_idx);
      frac = longint'(fr);
    endfunction

    function longint bicubic(bit second, int i, int j, int nx, int nq,
                             longint t, longint u, output bit ok);
      longint col[4];
      longint row[4];
      int a, b, k;
      for (int di = -1; di <= 2; di++) begin
        a = i + di;
        a = a < 0 ? 0 : (a > nx - 1 ? nx - 1 : a);
        for (int dj = -1; dj <= 2; dj++) begin
          b = j + dj;
          b = b < 0 ? 0 : (b > nq - 1 ? nq - 1 : b);
          k = a * NPTS + b;
          if (!(second ? lp[k] : tp[k])) begin
            ok = 0;
            return 0;
          end
          row[dj + 1] = second ? lv[k] : tv[k];
        end
        col[di + 1] = cubic(u, row[0], row[1], row[2], row[3]);
      end
      ok = 1;
      return sat(cubic(t, col[0], col[1], col[2], col[3]), 32);
    endfunction

    function void note(request_t r);
      int k, nx, nq, i, j;
      longint t, u;
      bit clamped, ok;
      result_t e;
      if (r.op == OP_WRITE) begin
        k = int'(r.wx) * NPTS + int'(r.wq);
        tv[k] = longint'(signed'(r.tval));
        tp[k] = r.tpres;
        lv[k] = longint'(signed'(r.lval));
        lp[k] = r.lpres;
        return;
      end
      clamped = 0;
      nx = limit_points(pts_x);
      nq = limit_points(pts_q);
      find_cell(longint'(signed'(r.log_x)), x_first, x_last, x_recip, nx, i, t, clamped);
      find_cell(longint'(signed'(r.log_q)), q_first, q_last, q_recip, nq, j, u, clamped);
      if (clamped) clamp_count = clamp_count + 1;
      e.tres = 32'(bicubic(0, i, j, nx, nq, t, u, ok));
      e.tvalid = ok;
      e.lres = 32'(bicubic(1, i, j, nx, nq, t, u, ok));
      e.lvalid = ok;
      e.clamped = clamped;
      pending.push_back(e);
    endfunction

    function void check(result_t r);
      result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result with no query outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.tres !== e.tres) begin
        $error("transverse_result expected %0d actual %0d", signed'(e.tres), signed'(r.tres));
        errors++;
      end
      if (r.tvalid !== e.tvalid) begin
        $error("transverse_valid expected %0b actual %0b", e.tvalid, r.tvalid);
        errors++;
      end
      if (r.lres !== e.lres) begin
        $error("longitudinal_result expected %0d actual %0d", signed'(e.lres),
               signed'(r.lres));
        errors++;
      end
      if (r.lvalid !== e.lvalid) begin
        $error("longitudinal_valid expected %0b actual %0b", e.lvalid, r.lvalid);
        errors++;
      end
      if (r.clamped !== e.clamped) begin
        $error("was_clamped expected %0b actual %0b", e.clamped, r.clamped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_X_FIRST;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic start = 0;
  logic busy;
  logic op_i = OP_WRITE;
  logic signed [31:0] log_x_i = '0, log_q_i = '0;
  logic [5:0] write_x_index_i = '0, write_q_index_i = '0;
  logic signed [31:0] transverse_value_i = '0, longitudinal_value_i = '0;
  logic transverse_present_i = 0, longitudinal_present_i = 0;
  logic done_o;
  logic signed [31:0] transverse_result_o, longitudinal_result_o;
  logic transverse_valid_o, longitudinal_valid_o, was_clamped_o;

  interp_scoreboard sb = new();
  int stall_cycles = 0;
  int n_queries = 0, n_writes = 0, n_phases = 0;
  bit no_idle = 0;

  bicubic_grid_interpolator_top DUT (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check('{transverse_result_o, transverse_valid_o, longitudinal_result_o,
                 longitudinal_valid_o, was_clamped_o});
    end
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // request stays raised until taken; caller lowers it only before a gap
  task automatic send(request_t r);
    start <= 1;
    op_i <= r.op;
    log_x_i <= r.log_x;
    log_q_i <= r.log_q;
    write_x_index_i <= r.wx;
    write_q_index_i <= r.wq;
    transverse_value_i <= r.tval;
    transverse_present_i <= r.tpres;
    longitudinal_value_i <= r.lval;
    longitudinal_present_i <= r.lpres;
    do @(posedge clk_i); while (busy);
    sb.note(r);
    if (r.op == OP_QUERY) n_queries++;
    else n_writes++;
  endtask

  task automatic idle_gap(bit allow);
    int r, g;
    r = $urandom_range(0, 99);
    g = r < 55 ? 0 : (r < 85 ? $urandom_range(1, 3) :
        (r < 97 ? $urandom_range(4, 15) : $urandom_range(20, 60)));
    if (!allow || no_idle) g = 0;
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // write enable stays high across a burst; the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  function automatic logic [31:0] recip_for(longint first, longint last, int n);
    longint span;
    span = last - first;
    if (span <= 0) return 32'($urandom);
    return 32'((longint'(n - 1) << 40) / span);
  endfunction

  task automatic apply_setting(int kind);
    longint xf, xl, qf, ql;
    int nx, nq, rx, rq;
    logic [31:0] xr, qr;
    xf = -longint'($urandom_range(0, 1 << 28));
    xl = xf + longint'($urandom_range(1 << 20, 1 << 30));
    qf = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
    ql = qf + longint'($urandom_range(1 << 20, 1 << 30));
    nx = $urandom_range(2, FILL);
    nq = $urandom_range(2, FILL);
    rx = nx;
    rq = nq;
    case (kind)
      1: begin
        xf = -64'sd2147483648;
        xl = 64'sd2147483647;
        qf = -64'sd2147483648;
        ql = 64'sd2147483647;
        nx = 64;
        nq = 64;
        rx = 64;
        rq = 64;
      end
      2: begin
        rx = 0;
        rq = 1;
        nx = 2;
        nq = 2;
      end
      3: begin
        rx = 127;
        rq = 100;
        nx = 64;
        nq = 64;
      end
      4: begin
        xf = ONE_Q24;
        xl = -ONE_Q24;
      end
      default: ;
    endcase
    xr = recip_for(xf, xl, nx);
    qr = recip_for(qf, ql, nq);
    if (kind == 5) begin
      xr = '0;
      qr = '1;
    end
    write_reg(CFG_X_FIRST, 32'(xf));
    write_reg(CFG_X_LAST, 32'(xl));
    write_reg(CFG_Q_FIRST, 32'(qf));
    write_reg(CFG_Q_LAST, 32'(ql));
    write_reg(CFG_X_RECIP, xr);
    write_reg(CFG_Q_RECIP, qr);
    write_reg(CFG_PTS_X, 32'(rx));
    write_reg(CFG_PTS_Q, 32'(rq));
    cfg_we_i <= 0;
  endtask

  function automatic logic [31:0] pick_coord(longint first, longint last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && first <= last)
      return 32'(first + longint'($urandom_range(0, 32'(last - first))));
    if (r < 85) return 32'((r < 78 ? first : last) + $urandom_range(0, 8) - 4);
    return $urandom;
  endfunction

  // keeps the stencil inside the filled corner when the grid in use is larger
  function automatic logic [31:0] pick_safe(longint first, longint last,
                                            longint unsigned recip, int pts);
    longint hi;
    int r;
    if (sb.limit_points(pts) <= FILL || first > last || recip == 0)
      return pick_coord(first, last);
    hi = first + longint'((64'(FILL - 2) << 40) / recip) - 1;
    if (hi < first) hi = first;
    if (hi >= last) return pick_coord(first, last);
    r = $urandom_range(0, 99);
    if (r < 75) return 32'(first + longint'($urandom_range(0, 32'(hi - first))));
    if (r < 85 && first > -64'sd2147483640)
      return 32'(first - longint'($urandom_range(1, 8)));
    if (r < 92) return 32'(first);
    return 32'(hi);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r < 10) return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    return $urandom;
  endfunction

  function automatic request_t random_write(logic [5:0] x, logic [5:0] q, int pct);
    request_t r;
    r.op = OP_WRITE;
    r.log_x = $urandom;
    r.log_q = $urandom;
    r.wx = x;
    r.wq = q;
    r.tval = pick_value();
    r.tpres = $urandom_range(0, 99) < pct;
    r.lval = pick_value();
    r.lpres = $urandom_range(0, 99) < pct;
    return r;
  endfunction

  function automatic request_t query(logic [31:0] x, logic [31:0] q);
    request_t r;
    r = random_write(6'($urandom), 6'($urandom), 50);
    r.op = OP_QUERY;
    r.log_x = x;
    r.log_q = q;
    return r;
  endfunction

  initial begin
    request_t r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // fill the corner of both tables that every stencil stays in
    for (int x = 0; x < FILL; x++)
      for (int q = 0; q < FILL; q++)
        send(random_write(6'(x), 6'(q), 97));

    // directed, register defaults
    r = random_write(6'd63, 6'd63, 100);
    r.tval = 32'h7fffffff;
    r.lval = 32'h80000000;
    send(r);
    r = random_write(6'd0, 6'd0, 100);
    r.tval = 32'h80000000;
    r.lval = 32'h7fffffff;
    send(r);
    send(random_write(6'd62, 6'd0, 0));
    send(query(32'h80000000, 32'h80000000));
    send(query(32'h0, 32'h0));
    send(query(32'hffffffff, 32'h00040000));
    send(query(32'h00040000, 32'h00000001));
    for (int k = 0; k < 8; k++)
      send(query(pick_safe(0, ONE_Q24, sb.x_recip, sb.pts_x),
                 pick_safe(0, ONE_Q24, sb.q_recip, sb.pts_q)));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(ph == 0 ? 6 : ph);
      n_phases++;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 135; k++) begin
        if ($urandom_range(0, 99) < 30) begin
          send(random_write(6'($urandom), 6'($urandom), 85));
        end else begin
          send(query(pick_safe(sb.x_first, sb.x_last, sb.x_recip, sb.pts_x),
                     pick_safe(sb.q_first, sb.q_last, sb.q_recip, sb.pts_q)));
        end
        idle_gap(k != 134);
      end
      drain();
    end

    $display("covered %0d queries and %0d table writes over %0d register settings",
             n_queries, n_writes, n_phases + 1);
    $display("%0d results checked, %0d queries clamped", sb.results_seen, sb.clamp_count);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
